@@ rtl/core/wcfb_pkg.sv @@
// ----------------------------------------------------------------------------
// wcfb_pkg
// shared types, constants and helpers of the wind class frame builder
// ----------------------------------------------------------------------------
package wcfb_pkg;

    localparam int FRAME_LEN = 21;
    localparam int IDX_W     = 5;
    localparam int NUM_LIM   = 9;
    localparam int HEAD_LEN  = 18;

    // byte positions after the fixed header
    localparam logic [IDX_W-1:0] IDX_DEV  = IDX_W'(18);
    localparam logic [IDX_W-1:0] IDX_CLS  = IDX_W'(19);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LEN - 1);

    localparam logic [7:0] START_BYTE = 8'h7E;

    // class thresholds, highest first
    localparam logic [15:0] CLASS_LIMITS [NUM_LIM] = '{
        16'd1100, 16'd1000, 16'd900, 16'd800, 16'd700,
        16'd600,  16'd500,  16'd430, 16'd400
    };

    // start, length, type, id, destination (0x13 escaped), 16-bit address, radius, options
    localparam logic [7:0] FRAME_HEAD [HEAD_LEN] = '{
        8'h7E, 8'h00, 8'h10, 8'h10, 8'h01, 8'h00, 8'h7D, 8'h33, 8'hA2,
        8'h00, 8'h40, 8'hE6, 8'h6E, 8'h6A, 8'hFF, 8'hFE, 8'h00, 8'h00
    };

    // low byte of the unescaped header sum from frame type through options
    localparam logic [7:0] HEAD_SUM = 8'hC1;

    typedef logic [3:0] wcfb_class_t;

    typedef struct packed {
        wcfb_class_t cls;
        logic [7:0]  led;
    } wcfb_item_t;

    typedef struct packed {
        wcfb_class_t cls;
        logic [7:0]  led;
        logic [7:0]  dev;
        logic [7:0]  chk;
    } wcfb_frame_t;

    function automatic logic [7:0] wcfb_led(input wcfb_class_t cls);
        logic [7:0] bar;
        case (cls)
            4'd0:    bar = 8'h00;
            4'd1:    bar = 8'h01;
            4'd2:    bar = 8'h03;
            4'd3:    bar = 8'h07;
            4'd4:    bar = 8'h0F;
            4'd5:    bar = 8'h1F;
            4'd6:    bar = 8'h3F;
            4'd7:    bar = 8'h7F;
            default: bar = 8'hFF;
        endcase
        return bar;
    endfunction

endpackage

@@ rtl/core/wcfb_classify.sv @@
// ----------------------------------------------------------------------------
// wcfb_classify
// two pipeline stages: threshold compares, then class and bar encode
// ----------------------------------------------------------------------------
module wcfb_classify #(
    parameter int SAMPLE_WIDTH = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_WIDTH-1:0] in_sample,
    output logic                    out_valid,
    input  logic                    out_ready,
    output wcfb_pkg::wcfb_item_t    out_item
);
    import wcfb_pkg::*;

    logic               v1_reg, v2_reg;
    logic [NUM_LIM-1:0] gt_reg, gt_next;
    wcfb_item_t         item_reg, item_next;
    logic               adv1, adv2;
    logic [15:0]        sample_ext;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign sample_ext = 16'(in_sample);

    always_comb begin
        for (int k = 0; k < NUM_LIM; k++) begin
            gt_next[k] = sample_ext > CLASS_LIMITS[k];
        end
    end

    // first threshold exceeded, counted from the top, sets the class
    always_comb begin
        item_next.cls = 4'd0;
        for (int k = NUM_LIM - 1; k >= 0; k--) begin
            if (gt_reg[k]) begin
                item_next.cls = 4'(NUM_LIM - k);
            end
        end
        item_next.led = wcfb_led(item_next.cls);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= in_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
        if (adv1 && in_valid) begin
            gt_reg <= gt_next;
        end
        if (adv2 && v1_reg) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/core/wcfb_check.sv @@
// ----------------------------------------------------------------------------
// wcfb_check
// pipeline stage that forms the frame checksum
// ----------------------------------------------------------------------------
module wcfb_check (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wcfb_pkg::wcfb_item_t  in_item,
    input  logic [7:0]            dev_num,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wcfb_pkg::wcfb_frame_t out_frame
);
    import wcfb_pkg::*;

    logic        v_reg;
    wcfb_frame_t frame_reg, frame_next;
    logic [7:0]  sum;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        sum            = 8'(HEAD_SUM + dev_num + {4'b0, in_item.cls});
        frame_next.cls = in_item.cls;
        frame_next.led = in_item.led;
        frame_next.dev = dev_num;
        frame_next.chk = 8'hFF - sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            frame_reg <= frame_next;
        end
    end

    assign out_valid = v_reg;
    assign out_frame = frame_reg;

endmodule

@@ rtl/core/wcfb_serial.sv @@
// ----------------------------------------------------------------------------
// wcfb_serial
// frame serializer with registered byte output, one byte per cycle while out_ready is high
// ----------------------------------------------------------------------------
module wcfb_serial (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wcfb_pkg::wcfb_frame_t in_frame,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_last,
    output wcfb_pkg::wcfb_class_t out_cls,
    output logic [7:0]            out_led
);
    import wcfb_pkg::*;

    logic             valid_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       byte_reg, byte_next;
    wcfb_frame_t      frame_reg;
    logic             last_taken, step;

    assign last_taken = valid_reg && out_ready && (idx_reg == IDX_LAST);
    assign step       = valid_reg && out_ready && (idx_reg != IDX_LAST);
    assign in_ready   = !valid_reg || last_taken;
    assign idx_next   = idx_reg + IDX_W'(1);

    always_comb begin
        case (idx_next)
            IDX_DEV:  byte_next = frame_reg.dev;
            IDX_CLS:  byte_next = {4'b0, frame_reg.cls};
            IDX_LAST: byte_next = frame_reg.chk;
            default:  byte_next = FRAME_HEAD[idx_next];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
            idx_reg   <= '0;
        end else if (step) begin
            idx_reg <= idx_next;
        end
        if (in_ready && in_valid) begin
            frame_reg <= in_frame;
            byte_reg  <= START_BYTE;
        end else if (step) begin
            byte_reg <= byte_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = idx_reg == IDX_LAST;
    assign out_cls   = frame_reg.cls;
    assign out_led   = frame_reg.led;

endmodule

@@ rtl/core/wind_class_frame_builder_top.sv @@
// ----------------------------------------------------------------------------
// wind_class_frame_builder_top
// wind sensor sample to API transmit request frame
// ----------------------------------------------------------------------------
// each accepted request on the slave side carries one wind sensor sample; the
// block grades it against a fixed threshold ladder into a class 0..9 with a
// matching led bar pattern and sends a 21-byte transmit request frame on the
// master side, one byte per request, tlast on the checksum byte. the frame
// serializer emits one byte per cycle while m_tready is high. a sample passes
// four register stages in order before its first byte shows: two classify
// stages, a checksum stage and the output register, the first of them loaded
// on the accepting edge. up to three more samples queue in the pipeline
// stages while a frame goes out. device_number is written through
// cfg_wr_en/cfg_wr_data, reset 1; the user must write it only while the block
// is idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module wind_class_frame_builder_top #(
    parameter int SAMPLE_WIDTH = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write, device_number
    input  logic                                cfg_wr_en,
    input  logic [7:0]                          cfg_wr_data,
    // sample requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,   // adc_sample
    // frame byte requests
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // frame_byte, wind_class, led_bar
    output logic                                m_tlast    // last_byte
);
    import wcfb_pkg::*;

    logic [7:0]  dev_num_reg;

    // classify to checksum handoff
    logic        cl_valid, cl_ready;
    wcfb_item_t  cl_item;

    // checksum to serializer handoff
    logic        ck_valid, ck_ready;
    wcfb_frame_t ck_frame;

    logic [7:0]  out_byte, out_led;
    wcfb_class_t out_cls;

    // device number register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_num_reg <= 8'd1;
        end else if (cfg_wr_en) begin
            dev_num_reg <= cfg_wr_data;
        end
    end

    // threshold compare and class encode, two stages
    wcfb_classify #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[SAMPLE_WIDTH-1:0]),
        .out_valid (cl_valid),
        .out_ready (cl_ready),
        .out_item  (cl_item)
    );

    // checksum stage
    wcfb_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cl_valid),
        .in_ready  (cl_ready),
        .in_item   (cl_item),
        .dev_num   (dev_num_reg),
        .out_valid (ck_valid),
        .out_ready (ck_ready),
        .out_frame (ck_frame)
    );

    // byte serializer with output register
    wcfb_serial u_serial (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ck_valid),
        .in_ready  (ck_ready),
        .in_frame  (ck_frame),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (out_byte),
        .out_last  (m_tlast),
        .out_cls   (out_cls),
        .out_led   (out_led)
    );

    // pack frame_byte low, then wind_class, then led_bar, zero fill
    assign m_tdata = {4'b0, out_led, out_cls, out_byte};

    // a frame goes out without gaps once started
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("frame interrupted before its last byte");

    // class never above 9
    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:8] <= 4'd9)
        else $error("wind class out of range");

    // led bar matches class
    a_led_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:12] == wcfb_led(m_tdata[11:8]))
        else $error("led bar does not match class");

    // a new frame opens with the start byte
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata[7:0] == START_BYTE)
        else $error("frame does not open with start byte");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the wind class frame builder
// ----------------------------------------------------------------------------
// samples go in through a queue-fed driver with random gaps, the frame byte
// stream is taken with random back-pressure, and every byte is compared with
// a frame predicted in the bench. device_number is changed between phases,
// each time after the block has drained.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import wcfb_pkg::*;

    localparam int          SAMPLE_W    = 12;
    localparam int          SAMPLE_BUS  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int          TX_LEN      = 21;
    localparam int          SETTLE      = 12;        // pipeline depth plus margin
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          RAND_PHASES = 6;
    localparam int          RAND_ITEMS  = 80;

    // one byte of the transmit request as it should appear on the master side
    typedef struct {
        logic [7:0]  data;
        logic        last;
        wcfb_class_t cls;
        logic [7:0]  led;
    } tx_byte_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [7:0]            cfg_wr_data = 8'h00;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_BUS-1:0] s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [23:0]           m_tdata;    // frame_byte, wind_class, led_bar
    logic                  m_tlast;    // last_byte

    logic [SAMPLE_BUS-1:0] samples_todo[$];   // requests not yet offered
    tx_byte_t              tx_bytes_due[$];   // predicted frame bytes, oldest first
    logic [7:0]            node_id = 8'd1;    // bench copy of device_number

    int unsigned errors        = 0;
    int unsigned samples_taken = 0;
    int unsigned bytes_checked = 0;
    int unsigned node_settings = 1;
    int unsigned cycle_count   = 0;
    int unsigned send_wait     = 0;
    int unsigned recv_wait     = 0;
    int unsigned calm_send     = 0;
    int unsigned calm_recv     = 0;
    logic [9:0]  classes_seen  = '0;

    wind_class_frame_builder_top #(
        .SAMPLE_WIDTH (SAMPLE_W)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // threshold ladder, strictly above each limit; bits above the sample
    // width are dropped first
    function automatic wcfb_class_t grade_sample(input logic [SAMPLE_BUS-1:0] raw);
        logic [SAMPLE_W-1:0] s;
        s = raw[SAMPLE_W-1:0];
        if (s > 1100)      return 4'd9;
        else if (s > 1000) return 4'd8;
        else if (s > 900)  return 4'd7;
        else if (s > 800)  return 4'd6;
        else if (s > 700)  return 4'd5;
        else if (s > 600)  return 4'd4;
        else if (s > 500)  return 4'd3;
        else if (s > 430)  return 4'd2;
        else if (s > 400)  return 4'd1;
        else               return 4'd0;
    endfunction

    // fixed part of the frame, destination 0x13 already escaped as 7D 33
    function automatic logic [7:0] header_byte(input int pos);
        case (pos)
            0:       return 8'h7E;
            2:       return 8'h10;
            3:       return 8'h10;
            4:       return 8'h01;
            6:       return 8'h7D;
            7:       return 8'h33;
            8:       return 8'hA2;
            10:      return 8'h40;
            11:      return 8'hE6;
            12:      return 8'h6E;
            13:      return 8'h6A;
            14:      return 8'hFF;
            15:      return 8'hFE;
            default: return 8'h00;
        endcase
    endfunction

    // queue the 21 bytes that one sample request should produce
    task automatic predict_frame(input logic [SAMPLE_BUS-1:0] raw);
        wcfb_class_t cls;
        logic [7:0]  bar;
        logic [7:0]  sum;
        tx_byte_t    b;
        cls = grade_sample(raw);
        bar = (cls >= 4'd8) ? 8'hFF : 8'((9'd1 << cls) - 9'd1);
        // checksum runs over unescaped bytes, frame type onward
        sum = 8'h00;
        for (int k = 3; k < 18; k++) begin
            if (k == 6)
                sum += 8'h13;
            else if (k != 7)
                sum += header_byte(k);
        end
        sum += node_id + 8'(cls);
        for (int k = 0; k < TX_LEN; k++) begin
            if (k < 18)
                b.data = header_byte(k);
            else if (k == 18)
                b.data = node_id;
            else if (k == 19)
                b.data = 8'(cls);
            else
                b.data = 8'hFF - sum;
            b.last = (k == TX_LEN - 1);
            b.cls  = cls;
            b.led  = bar;
            tx_bytes_due.push_back(b);
        end
        classes_seen[cls] = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly no gap, some short ones, a few long; calm stretches have none
    function automatic int unsigned next_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(20, 60);
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(12, 40);
    endfunction

    // samples cluster around the thresholds, the rest spread over 0..1200 or the whole bus
    function automatic logic [SAMPLE_BUS-1:0] random_sample();
        int unsigned          pick;
        int                   edge_val;
        logic [SAMPLE_BUS-1:0] v;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            case ($urandom_range(0, 8))
                0:       edge_val = 1100;
                1:       edge_val = 1000;
                2:       edge_val = 900;
                3:       edge_val = 800;
                4:       edge_val = 700;
                5:       edge_val = 600;
                6:       edge_val = 500;
                7:       edge_val = 430;
                default: edge_val = 400;
            endcase
            v = SAMPLE_BUS'(edge_val + $urandom_range(0, 4) - 2);
            // unused upper bits must not change the class
            if ($urandom_range(0, 3) == 0)
                v[SAMPLE_BUS-1:SAMPLE_W] = (SAMPLE_BUS - SAMPLE_W)'($urandom);
        end else if (pick < 8) begin
            v = SAMPLE_BUS'($urandom_range(0, 1200));
        end else begin
            v = SAMPLE_BUS'($urandom);
        end
        return v;
    endfunction

    // wait until the driver is empty and every predicted byte has arrived,
    // then give the pipeline time to settle
    task automatic drain_block();
        @(negedge aclk);
        while (samples_todo.size() != 0 || s_tvalid || tx_bytes_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_node(input logic [7:0] value);
        drain_block();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        node_id     = value;
        node_settings++;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued samples, a random gap after each request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_wait = 0;
        end else begin
            // a request taken at this edge is predicted right away
            if (s_tvalid && s_tready) begin
                predict_frame(s_tdata);
                samples_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait == 0 && samples_todo.size() != 0) begin
                    s_tdata   <= samples_todo.pop_front();
                    s_tvalid  <= 1'b1;
                    send_wait = next_gap(calm_send);
                end else begin
                    s_tvalid <= 1'b0;
                    if (send_wait != 0)
                        send_wait--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, each byte checked against the oldest
    // prediction
    // ------------------------------------------------------------------
    task automatic flag_field(input string what, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
        errors++;
        $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, exp_v, act_v);
    endtask

    task automatic check_tx_byte();
        tx_byte_t want;
        if (tx_bytes_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected frame byte, expected none, got %06h last %0b",
                     $time, m_tdata, m_tlast);
        end else begin
            want = tx_bytes_due.pop_front();
            // tdata: frame_byte [7:0], wind_class [11:8], led_bar [19:12]
            if (m_tdata[7:0] !== want.data)
                flag_field("frame_byte", want.data, m_tdata[7:0]);
            if (m_tlast !== want.last)
                flag_field("last_byte", 8'(want.last), 8'(m_tlast));
            if (m_tdata[11:8] !== want.cls)
                flag_field("wind_class", 8'(want.cls), 8'(m_tdata[11:8]));
            if (m_tdata[19:12] !== want.led)
                flag_field("led_bar", want.led, m_tdata[19:12]);
            bytes_checked++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_tx_byte();
            if (recv_wait != 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready  <= 1'b1;
                recv_wait = next_gap(calm_recv);
            end
        end
    end

    // hard stop if the stream hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due",
                     cycle_count, tx_bytes_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: every class boundary on both sides, the full-scale and
        // zero readings, and upper bus bits that must be ignored; runs with
        // the reset node number
        samples_todo.push_back(16'd0);
        samples_todo.push_back(16'd399);
        samples_todo.push_back(16'd400);    // exactly 400 stays class 0
        samples_todo.push_back(16'd401);
        samples_todo.push_back(16'd430);
        samples_todo.push_back(16'd431);
        samples_todo.push_back(16'd500);
        samples_todo.push_back(16'd501);
        samples_todo.push_back(16'd600);
        samples_todo.push_back(16'd601);
        samples_todo.push_back(16'd700);
        samples_todo.push_back(16'd701);
        samples_todo.push_back(16'd800);
        samples_todo.push_back(16'd801);
        samples_todo.push_back(16'd900);
        samples_todo.push_back(16'd901);
        samples_todo.push_back(16'd1000);
        samples_todo.push_back(16'd1001);
        samples_todo.push_back(16'd1100);
        samples_todo.push_back(16'd1101);
        samples_todo.push_back(16'd4095);
        samples_todo.push_back(16'hF190);   // 400 with upper bits set
        samples_todo.push_back(16'hA44D);   // 1101 with upper bits set
        samples_todo.push_back(16'hFFFF);

        // random phases, node number changed only once the block is idle
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       set_node(8'h00);
                1:       set_node(8'hFF);
                default: set_node(8'($urandom));
            endcase
            for (int i = 0; i < RAND_ITEMS; i++)
                samples_todo.push_back(random_sample());
        end

        drain_block();

        $display("covered %0d samples under %0d node numbers, %0d frame bytes checked",
                 samples_taken, node_settings, bytes_checked);
        $display("wind classes reached (bit per class, 9 down to 0): %b", classes_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
